// ===== sv/csrc_pkg.sv =====
`default_nettype none

package csrc_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int MAX_RUN_DEF     = 16;

    localparam int POS_W  = 31;
    localparam int ADDR_W = 2;
    localparam int DATA_W = 32;

    localparam logic [ADDR_W-1:0] ADDR_STEP_RATIO = 2'd0;

    typedef enum logic [1:0] {
        COEF_B,
        COEF_C,
        COEF_V1
    } coef_sel_t;

    typedef struct packed {
        logic      capture;
        logic      mul;
        logic      mul_first;
        logic      add;
        coef_sel_t coef_sel;
        logic      load_result;
        logic      load_bypass;
        logic      finish;
    } csrc_cmd_t;

    typedef struct packed {
        logic bypass;
        logic below_one;
        logic out_free;
        logic run_last;
    } csrc_status_t;

endpackage

`default_nettype wire

// ===== sv/csrc_ctrl.sv =====
`default_nettype none

module csrc_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire csrc_pkg::csrc_status_t status,
    output csrc_pkg::csrc_cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_ADD1,
        S_MUL2,
        S_ADD2,
        S_MUL3,
        S_ADD3,
        S_OUT,
        S_BYP,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;
    logic   stall_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.coef_sel = csrc_pkg::COEF_B;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (status.bypass)
                    begin
                        state_next = S_BYP;
                    end
                    else if (status.below_one)
                    begin
                        state_next = S_MUL1;
                    end
                    else
                    begin
                        state_next = S_FIN;
                    end
                end
            end
            S_MUL1:
            begin
                cmd.mul       = 1'b1;
                cmd.mul_first = 1'b1;
                state_next    = S_ADD1;
            end
            S_ADD1:
            begin
                cmd.add      = 1'b1;
                cmd.coef_sel = csrc_pkg::COEF_B;
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD2;
            end
            S_ADD2:
            begin
                cmd.add      = 1'b1;
                cmd.coef_sel = csrc_pkg::COEF_C;
                state_next   = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul    = 1'b1;
                state_next = S_ADD3;
            end
            S_ADD3:
            begin
                cmd.add      = 1'b1;
                cmd.coef_sel = csrc_pkg::COEF_V1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = status.run_last ? S_FIN : S_MUL1;
                end
            end
            S_BYP:
            begin
                if (status.out_free)
                begin
                    cmd.load_bypass = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stall_next = (state_next != S_IDLE);
    assign in_stall   = stall_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/csrc_datapath.sv =====
`default_nettype none

module csrc_datapath #(
    parameter int SAMPLE_BITS = csrc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = csrc_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = csrc_pkg::MAX_RUN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire csrc_pkg::csrc_cmd_t           cmd,
    output csrc_pkg::csrc_status_t             status,
    input  wire logic [csrc_pkg::POS_W-1:0]    step_ratio,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    output logic signed [SAMPLE_BITS-1:0]      out_left,
    output logic signed [SAMPLE_BITS-1:0]      out_right,
    output logic                               last_of_run,
    output logic                               out_valid,
    input  wire logic                          out_stall
);

    localparam int PW     = csrc_pkg::POS_W;
    localparam int ACC_W  = SAMPLE_BITS + 5;
    localparam int PROD_W = ACC_W + FRAC_BITS + 1;
    localparam int CNT_W  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    localparam logic [PW-1:0] POS_ONE = PW'(64'd1 << FRAC_BITS);
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};
    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    function automatic logic signed [ACC_W-1:0] sx(input logic signed [SAMPLE_BITS-1:0] v);
        return ACC_W'(v);
    endfunction

    logic [PW-1:0]                pos_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic signed [SAMPLE_BITS-1:0] hist_reg [2][4];
    logic signed [SAMPLE_BITS-1:0] smp_reg [2];
    logic signed [ACC_W-1:0]      acc_reg [2];
    logic signed [PROD_W-1:0]     prod_reg [2];
    logic signed [SAMPLE_BITS-1:0] out_reg [2];
    logic                         last_reg;
    logic                         oval_reg;

    logic signed [ACC_W-1:0]      coef_a [2];
    logic signed [ACC_W-1:0]      coef_b [2];
    logic signed [ACC_W-1:0]      coef_c [2];
    logic signed [ACC_W-1:0]      coef_v1 [2];
    logic signed [ACC_W-1:0]      mul_op [2];
    logic signed [PROD_W-1:0]     prod_next [2];
    logic signed [PROD_W-1:0]     rnd [2];
    logic signed [ACC_W-1:0]      acc_next [2];
    logic signed [ACC_W-1:0]      coef_sel [2];
    logic signed [SAMPLE_BITS-1:0] sat [2];
    logic signed [FRAC_BITS:0]    frac;
    logic [PW:0]                  pos_sum;
    logic [PW-1:0]                pos_adv;
    logic                         out_free;

    assign frac     = {1'b0, pos_reg[FRAC_BITS-1:0]};
    assign pos_sum  = {1'b0, pos_reg} + {1'b0, step_ratio};
    assign pos_adv  = pos_sum[PW] ? POS_MAX : pos_sum[PW-1:0];
    assign out_free = !oval_reg || !out_stall;

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            coef_a[ch]  = sx(hist_reg[ch][3]) - sx(hist_reg[ch][2])
                        - sx(hist_reg[ch][0]) + sx(hist_reg[ch][1]);
            coef_b[ch]  = sx(hist_reg[ch][0]) - sx(hist_reg[ch][1]) - coef_a[ch];
            coef_c[ch]  = sx(hist_reg[ch][2]) - sx(hist_reg[ch][0]);
            coef_v1[ch] = sx(hist_reg[ch][1]);
            mul_op[ch]  = cmd.mul_first ? coef_a[ch] : acc_reg[ch];
            prod_next[ch] = PROD_W'(mul_op[ch]) * PROD_W'(frac);
            case (cmd.coef_sel)
                csrc_pkg::COEF_B:  coef_sel[ch] = coef_b[ch];
                csrc_pkg::COEF_C:  coef_sel[ch] = coef_c[ch];
                csrc_pkg::COEF_V1: coef_sel[ch] = coef_v1[ch];
                default:           coef_sel[ch] = coef_b[ch];
            endcase
            rnd[ch]      = prod_reg[ch] + HALF;
            acc_next[ch] = $signed(rnd[ch][FRAC_BITS +: ACC_W]) + coef_sel[ch];
            if (acc_reg[ch] > SAT_HI)
            begin
                sat[ch] = SAT_HI[SAMPLE_BITS-1:0];
            end
            else if (acc_reg[ch] < SAT_LO)
            begin
                sat[ch] = SAT_LO[SAMPLE_BITS-1:0];
            end
            else
            begin
                sat[ch] = acc_reg[ch][SAMPLE_BITS-1:0];
            end
        end
    end

    always_comb
    begin
        status.bypass    = (step_ratio == POS_ONE);
        status.below_one = (pos_reg < POS_ONE);
        status.out_free  = out_free;
        status.run_last  = (pos_adv >= POS_ONE) || (cnt_reg == CNT_W'(MAX_RUN - 1));
    end

    // control state and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_ONE;
            cnt_reg  <= '0;
            oval_reg <= 1'b0;
            for (int ch = 0; ch < 2; ch++)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    hist_reg[ch][k] <= '0;
                end
            end
        end
        else
        begin
            if (cmd.load_result || cmd.load_bypass)
            begin
                oval_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                oval_reg <= 1'b0;
            end
            if (cmd.load_result)
            begin
                pos_reg <= pos_adv;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.finish)
            begin
                pos_reg <= (pos_reg >= POS_ONE) ? pos_reg - POS_ONE : '0;
                cnt_reg <= '0;
                for (int ch = 0; ch < 2; ch++)
                begin
                    hist_reg[ch][0] <= hist_reg[ch][1];
                    hist_reg[ch][1] <= hist_reg[ch][2];
                    hist_reg[ch][2] <= hist_reg[ch][3];
                    hist_reg[ch][3] <= smp_reg[ch];
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            smp_reg[0] <= sample_left;
            smp_reg[1] <= sample_right;
        end
        for (int ch = 0; ch < 2; ch++)
        begin
            if (cmd.mul)
            begin
                prod_reg[ch] <= prod_next[ch];
            end
            if (cmd.add)
            begin
                acc_reg[ch] <= acc_next[ch];
            end
            if (cmd.load_result)
            begin
                out_reg[ch] <= sat[ch];
            end
            else if (cmd.load_bypass)
            begin
                out_reg[ch] <= smp_reg[ch];
            end
        end
        if (cmd.load_result)
        begin
            last_reg <= status.run_last;
        end
        else if (cmd.load_bypass)
        begin
            last_reg <= 1'b1;
        end
    end

    assign out_left    = out_reg[0];
    assign out_right   = out_reg[1];
    assign last_of_run = last_reg;
    assign out_valid   = oval_reg;

endmodule

`default_nettype wire

// ===== sv/cubic_sample_rate_converter.sv =====
`default_nettype none

// stereo cubic resampler: each engine sample pair transfer yields zero to MAX_RUN host
// sample pairs, one for each read position below one, interpolated from a four-sample
// history and saturated; last_of_run marks the final pair of a run. an item runs an accept
// step, then for each result six multiply/round-add steps of the horner sequencer on one
// multiplier per channel plus one output load, and a finish step that moves the position
// and shifts the history; the output load also waits while out_stall holds a pending
// result. with step_ratio exactly one the block passes each pair straight through.
// step_ratio sits at byte address 0, unsigned with FRAC_BITS fraction bits; the user must
// write it only while the block is idle, as the block itself does not enforce this.
module cubic_sample_rate_converter #(
    parameter int SAMPLE_BITS = csrc_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = csrc_pkg::FRAC_BITS_DEF,
    parameter int MAX_RUN     = csrc_pkg::MAX_RUN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [csrc_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [csrc_pkg::DATA_W-1:0]   pwdata,
    output logic [csrc_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0]      out_left,
    output logic signed [SAMPLE_BITS-1:0]      out_right,
    output logic                               last_of_run
);

    localparam int PW = csrc_pkg::POS_W;
    localparam int DW = csrc_pkg::DATA_W;
    localparam logic [PW-1:0] STEP_ONE = PW'(64'd1 << FRAC_BITS);

    logic [PW-1:0]          step_reg;
    logic                   cfg_wr;
    csrc_pkg::csrc_cmd_t    cmd;
    csrc_pkg::csrc_status_t status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == csrc_pkg::ADDR_STEP_RATIO);
    assign prdata = (paddr == csrc_pkg::ADDR_STEP_RATIO) ? DW'(step_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_ONE;
        end
        else if (cfg_wr)
        begin
            step_reg <= pwdata[PW-1:0];
        end
    end

    csrc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    csrc_datapath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS),
        .MAX_RUN     (MAX_RUN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .step_ratio   (step_reg),
        .sample_left  (sample_left),
        .sample_right (sample_right),
        .out_left     (out_left),
        .out_right    (out_right),
        .last_of_run  (last_of_run),
        .out_valid    (out_valid),
        .out_stall    (out_stall)
    );

endmodule

`default_nettype wire
